// ----- rtl/tprt_pkg.sv -----
// ----------------------------------------------------------------------------
// tprt_pkg: shared types and constants for the touch record parser
// Item structs, register map codes, frame byte codes and sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package tprt_pkg;

  // Sizes
  localparam int BODY_BYTES  = 24;
  localparam int COORD_WIDTH = 12;
  localparam int LEN_W       = $clog2(BODY_BYTES);
  localparam int VALUE_W     = COORD_WIDTH + 1;
  localparam int AGE_W       = 20;
  localparam int MAXC_W      = 12;

  localparam logic [AGE_W-1:0]   AGE_MAX   = {AGE_W{1'b1}};
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // Register map (byte address 4*index, index is paddr[2])
  localparam logic REG_TTL_TICKS   = 1'b0;
  localparam logic REG_COORD_LIMIT = 1'b1;

  localparam logic [AGE_W-1:0]  TTL_RESET  = 20'd250;
  localparam logic [MAXC_W-1:0] MAXC_RESET = 12'd4095;

  // Item operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Byte codes
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic                   touch_down;
    logic [COORD_WIDTH-1:0] touch_x;
    logic [COORD_WIDTH-1:0] touch_y;
    logic                   record_accepted;
  } out_item_t;

  typedef struct packed {
    logic [AGE_W-1:0]  ttl_ticks;
    logic [MAXC_W-1:0] coord_limit;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/tprt_parser.sv -----
// ----------------------------------------------------------------------------
// tprt_parser: record scanner and press tracker
// Holds the frame and number state; gives the result for the item at its
// input from the next-state values, and commits the state when it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tprt_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_take,
  input  wire tprt_pkg::in_item_t item,
  input  wire tprt_pkg::cfg_t     cfg,
  output tprt_pkg::out_item_t     result
);

  typedef enum logic [1:0] {PH_IDLE, PH_ESC, PH_BODY} phase_t;
  typedef enum logic [1:0] {NP_BLANKS, NP_SIGN, NP_DIGITS} num_phase_t;

  localparam logic [1:0] FIELD_D = 2'd2;

  phase_t                               phase_r, phase_nxt;
  logic [tprt_pkg::LEN_W-1:0]           len_r, len_nxt;
  logic [1:0]                           fnum_r, fnum_nxt;
  num_phase_t                           np_r, np_nxt;
  logic [tprt_pkg::VALUE_W-1:0]         val_r, val_nxt;
  logic                                 neg_r, neg_nxt;
  logic                                 bad_r, bad_nxt;
  logic                                 ended_r, ended_nxt;
  logic [tprt_pkg::COORD_WIDTH-1:0]     hx_r, hx_nxt, hy_r, hy_nxt;
  logic                                 active_r, active_nxt;
  logic [tprt_pkg::COORD_WIDTH-1:0]     px_r, px_nxt, py_r, py_nxt;
  logic [tprt_pkg::AGE_W-1:0]           age_r, age_nxt;
  logic                                 accepted;

  logic [7:0]                   c;
  logic                         is_digit, is_blank, len_full, coord_ok;
  logic [tprt_pkg::VALUE_W+3:0] dsum;

  assign c        = item.rx_byte;
  assign is_digit = (c >= tprt_pkg::CH_0) && (c <= tprt_pkg::CH_9);
  assign is_blank = (c == tprt_pkg::CH_SPACE) || (c == tprt_pkg::CH_TAB) ||
                    (c == tprt_pkg::CH_VT) || (c == tprt_pkg::CH_FF);
  // value*10 + digit
  assign dsum = {1'b0, val_r, 3'b000} + {3'b000, val_r, 1'b0} +
                {{(tprt_pkg::VALUE_W){1'b0}}, c[3:0]};
  assign len_full = ({1'b0, len_r} + 1'b1) >= (tprt_pkg::LEN_W+1)'(tprt_pkg::BODY_BYTES);
  // "-0" passes
  assign coord_ok = (!neg_r || (val_r == '0)) && (val_r <= {1'b0, cfg.coord_limit});

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    fnum_nxt   = fnum_r;
    np_nxt     = np_r;
    val_nxt    = val_r;
    neg_nxt    = neg_r;
    bad_nxt    = bad_r;
    ended_nxt  = ended_r;
    hx_nxt     = hx_r;
    hy_nxt     = hy_r;
    active_nxt = active_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    age_nxt    = age_r;
    accepted   = 1'b0;

    if (item.operation == tprt_pkg::OP_TICK) begin
      if (age_r != tprt_pkg::AGE_MAX) begin
        age_nxt = age_r + 1'b1;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (c == tprt_pkg::CH_ESC) begin
            phase_nxt = PH_ESC;
          end
        end
        PH_ESC: begin
          if (c == tprt_pkg::CH_T) begin
            phase_nxt = PH_BODY;
          end else if (c != tprt_pkg::CH_ESC) begin
            phase_nxt = PH_IDLE;
          end
          len_nxt   = '0;
          fnum_nxt  = '0;
          bad_nxt   = 1'b0;
          ended_nxt = 1'b0;
          np_nxt    = NP_BLANKS;
          val_nxt   = '0;
          neg_nxt   = 1'b0;
        end
        PH_BODY: begin
          if (c == tprt_pkg::CH_ESC) begin
            phase_nxt = PH_ESC;
            len_nxt   = '0;
            fnum_nxt  = '0;
            bad_nxt   = 1'b0;
            ended_nxt = 1'b0;
            np_nxt    = NP_BLANKS;
            val_nxt   = '0;
            neg_nxt   = 1'b0;
          end else if ((c == tprt_pkg::CH_LF) || (c == tprt_pkg::CH_CR)) begin
            phase_nxt = PH_IDLE;
            if (!bad_r && (fnum_r == FIELD_D) && (np_r == NP_DIGITS)) begin
              if (val_r == '0) begin
                active_nxt = 1'b0;
                accepted   = 1'b1;
              end else if ((val_r == tprt_pkg::VALUE_W'(1)) && !neg_r) begin
                px_nxt     = hx_r;
                py_nxt     = hy_r;
                active_nxt = 1'b1;
                age_nxt    = '0;
                accepted   = 1'b1;
              end
            end
          end else if (len_full) begin
            // overlong body: drop
            phase_nxt = PH_IDLE;
          end else begin
            len_nxt = len_r + 1'b1;
            if (!ended_r && !bad_r) begin
              if (c == tprt_pkg::CH_NUL) begin
                ended_nxt = 1'b1;
              end else if (is_digit) begin
                val_nxt = (dsum > {4'b0000, tprt_pkg::VALUE_MAX}) ?
                          tprt_pkg::VALUE_MAX : dsum[tprt_pkg::VALUE_W-1:0];
                np_nxt  = NP_DIGITS;
              end else if (np_r == NP_BLANKS) begin
                if (c == tprt_pkg::CH_PLUS || c == tprt_pkg::CH_MINUS) begin
                  neg_nxt = (c == tprt_pkg::CH_MINUS);
                  np_nxt  = NP_SIGN;
                end else if (!is_blank) begin
                  bad_nxt = 1'b1;
                end
              end else if ((np_r == NP_DIGITS) && (c == tprt_pkg::CH_COMMA) &&
                           (fnum_r != FIELD_D)) begin
                if (!coord_ok) begin
                  bad_nxt = 1'b1;
                end else begin
                  if (fnum_r == 2'd0) begin
                    hx_nxt = val_r[tprt_pkg::COORD_WIDTH-1:0];
                  end else begin
                    hy_nxt = val_r[tprt_pkg::COORD_WIDTH-1:0];
                  end
                  fnum_nxt = fnum_r + 1'b1;
                  np_nxt   = NP_BLANKS;
                  val_nxt  = '0;
                  neg_nxt  = 1'b0;
                end
              end else begin
                bad_nxt = 1'b1;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      len_r    <= '0;
      fnum_r   <= '0;
      np_r     <= NP_BLANKS;
      val_r    <= '0;
      neg_r    <= 1'b0;
      bad_r    <= 1'b0;
      ended_r  <= 1'b0;
      hx_r     <= '0;
      hy_r     <= '0;
      active_r <= 1'b0;
      px_r     <= '0;
      py_r     <= '0;
      age_r    <= '0;
    end else if (item_take) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      fnum_r   <= fnum_nxt;
      np_r     <= np_nxt;
      val_r    <= val_nxt;
      neg_r    <= neg_nxt;
      bad_r    <= bad_nxt;
      ended_r  <= ended_nxt;
      hx_r     <= hx_nxt;
      hy_r     <= hy_nxt;
      active_r <= active_nxt;
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      age_r    <= age_nxt;
    end
  end

  assign result.touch_down      = active_nxt && (age_nxt <= cfg.ttl_ticks);
  assign result.touch_x         = px_nxt;
  assign result.touch_y         = py_nxt;
  assign result.record_accepted = accepted;

endmodule

`default_nettype wire

// ----- rtl/touch_record_parser_ttl_top.sv -----
// ----------------------------------------------------------------------------
// touch_record_parser_ttl_top: touch record parser with press expiry
// Results are registered. Throughput: one item per cycle while in_stall is low;
// the parser state updates in a single pass. A two-entry output stage (result
// register plus skid) lets the input keep going for one item while out_stall
// is high; in_stall rises when it fills.
// Reset (rst_n low, synchronous): parser idle, no press, registers at
// ttl_ticks = 250 and coord_limit = 4095, output stage empty.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_record_parser_ttl_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input items
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tprt_pkg::in_item_t  in_data,
  // result items
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tprt_pkg::out_item_t      out_data,
  // APB-style register port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // --------------------------------------------------------------------------
  // Configuration registers. Index is paddr[2]; low address bits are ignored.
  // --------------------------------------------------------------------------
  tprt_pkg::cfg_t cfg_r;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ttl_ticks   <= tprt_pkg::TTL_RESET;
      cfg_r.coord_limit <= tprt_pkg::MAXC_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == tprt_pkg::REG_TTL_TICKS) begin
        cfg_r.ttl_ticks <= pwdata[tprt_pkg::AGE_W-1:0];
      end else begin
        cfg_r.coord_limit <= pwdata[tprt_pkg::MAXC_W-1:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      tprt_pkg::REG_TTL_TICKS:   prdata = {{(32-tprt_pkg::AGE_W){1'b0}}, cfg_r.ttl_ticks};
      tprt_pkg::REG_COORD_LIMIT: prdata = {{(32-tprt_pkg::MAXC_W){1'b0}}, cfg_r.coord_limit};
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Parser: result is formed combinationally from the item at the input
  // --------------------------------------------------------------------------
  logic                in_take;
  tprt_pkg::out_item_t res;

  assign in_take = in_valid && !in_stall;

  tprt_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_take (in_take),
    .item      (in_data),
    .cfg       (cfg_r),
    .result    (res)
  );

  // --------------------------------------------------------------------------
  // Output stage: result register plus one skid entry
  // --------------------------------------------------------------------------
  logic                out_v_r, skid_v_r;
  tprt_pkg::out_item_t out_d_r, skid_d_r;

  assign in_stall  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && out_stall) begin
      // result held; a new item parks in the skid entry
      if (in_take) begin
        skid_v_r <= 1'b1;
        skid_d_r <= res;
      end
    end else if (skid_v_r) begin
      // drain the skid entry (no item is taken while it is full)
      out_v_r  <= 1'b1;
      out_d_r  <= skid_d_r;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= in_take;
      if (in_take) begin
        out_d_r <= res;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry full while result register empty");

  a_park_in_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && out_v_r && out_stall) |=> (skid_v_r && out_v_r))
    else $error("item taken under output stall was not kept");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("output stage not empty after reset");

endmodule

`default_nettype wire
